@@ hw/rtl/command_driven_servo_pulse_generator_defines.svh @@
// assertion macros used by the servo pulse generator port-level checker
`ifndef COMMAND_DRIVEN_SERVO_PULSE_GENERATOR_DEFINES_SVH
`define COMMAND_DRIVEN_SERVO_PULSE_GENERATOR_DEFINES_SVH

// clocked assertion, muted while reset is asserted
`define CDSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CDSP_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cdsp_pkg.sv @@
// shared types and constants of the servo pulse generator
package cdsp_pkg;

  localparam int CHANNELS   = 3;
  localparam int WIDTH_BITS = 10;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W      = 12;
  localparam int VAL_W      = 10;
  localparam int SAT_W      = (WIDTH_BITS > VAL_W) ? WIDTH_BITS : VAL_W;
  localparam int CMP_W      = (WIDTH_BITS > CNT_W) ? WIDTH_BITS : CNT_W;
  localparam int OUT_BITS   = 3;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 12;

  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = '1;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET =
    (90 > ((1 << WIDTH_BITS) - 1)) ? WIDTH_MAX : WIDTH_BITS'(90);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CNT_W-1:0] FRAME_TICKS_RESET = 12'd1670;
  localparam logic [CNT_W-1:0] LEAD_TICKS_RESET  = 12'd40;
  localparam logic             GROUP_RESET       = 1'b1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_GROUP = 2'd2;

  localparam logic [7:0] CHR_S = 8'h73;
  localparam logic [7:0] CHR_0 = 8'h30;
  localparam logic [7:0] CHR_9 = 8'h39;
  localparam logic [7:0] CHR_1 = 8'h31;
  localparam logic [7:0] CHR_4 = 8'h34;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_CHAN,
    PS_D0,
    PS_D1,
    PS_D2
  } parse_stage_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_SET,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [CH_W-1:0]       ch;
    logic [WIDTH_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] frame_ticks;
    logic [CNT_W-1:0] lead_ticks;
  } timing_cfg_t;

endpackage

@@ hw/rtl/cdsp_front.sv @@
// command parser: classifies each item and turns byte commands into width writes
module cdsp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          op,
  input  logic [7:0]    rx_byte,
  input  logic          group,
  output logic          push,
  output cdsp_pkg::cmd_t cmd
);

  cdsp_pkg::parse_stage_t          stage_r, stage_nxt;
  logic [cdsp_pkg::CH_W-1:0]       chan_r, chan_nxt;
  logic [cdsp_pkg::VAL_W-1:0]      value_r, value_nxt;

  logic                            is_digit;
  logic [3:0]                      digit;
  logic [7:0]                      base;
  logic [7:0]                      off;
  logic                            chan_ok;
  logic [cdsp_pkg::VAL_W-1:0]      acc;
  logic [cdsp_pkg::SAT_W-1:0]      acc_ext;
  logic [cdsp_pkg::WIDTH_BITS-1:0] acc_sat;

  assign is_digit = (rx_byte >= cdsp_pkg::CHR_0) && (rx_byte <= cdsp_pkg::CHR_9);
  assign digit    = 4'(rx_byte - cdsp_pkg::CHR_0);
  assign base     = group ? cdsp_pkg::CHR_4 : cdsp_pkg::CHR_1;
  assign off      = rx_byte - base;
  assign chan_ok  = (rx_byte >= base) && (off < 8'(cdsp_pkg::CHANNELS));
  assign acc      = cdsp_pkg::VAL_W'(value_r * cdsp_pkg::VAL_W'(10))
                  + cdsp_pkg::VAL_W'(digit);
  assign acc_ext  = cdsp_pkg::SAT_W'(acc);
  assign acc_sat  = (acc_ext > cdsp_pkg::SAT_W'(cdsp_pkg::WIDTH_MAX)) ?
                    cdsp_pkg::WIDTH_MAX : cdsp_pkg::WIDTH_BITS'(acc_ext);

  always_comb begin
    stage_nxt = stage_r;
    if (rx_byte == cdsp_pkg::CHR_S) begin
      stage_nxt = cdsp_pkg::PS_CHAN;
    end else begin
      case (stage_r)
        cdsp_pkg::PS_CHAN: stage_nxt = chan_ok  ? cdsp_pkg::PS_D0 : cdsp_pkg::PS_IDLE;
        cdsp_pkg::PS_D0:   stage_nxt = is_digit ? cdsp_pkg::PS_D1 : cdsp_pkg::PS_IDLE;
        cdsp_pkg::PS_D1:   stage_nxt = is_digit ? cdsp_pkg::PS_D2 : cdsp_pkg::PS_IDLE;
        default:           stage_nxt = cdsp_pkg::PS_IDLE;
      endcase
    end
  end

  always_comb begin
    chan_nxt  = chan_r;
    value_nxt = value_r;
    cmd.kind  = (op == cdsp_pkg::OP_TICK) ? cdsp_pkg::CMD_TICK : cdsp_pkg::CMD_NONE;
    cmd.ch    = chan_r;
    cmd.value = acc_sat;
    if (rx_byte == cdsp_pkg::CHR_S) begin
      value_nxt = '0;
    end else begin
      case (stage_r)
        cdsp_pkg::PS_CHAN: begin
          if (chan_ok) begin
            chan_nxt  = cdsp_pkg::CH_W'(off);
            value_nxt = '0;
          end
        end
        cdsp_pkg::PS_D0, cdsp_pkg::PS_D1: begin
          if (is_digit) begin
            value_nxt = acc;
          end
        end
        cdsp_pkg::PS_D2: begin
          if (is_digit) begin
            value_nxt = acc;
            if (op == cdsp_pkg::OP_BYTE) begin
              cmd.kind = cdsp_pkg::CMD_SET;
            end
          end
        end
        default: begin
          value_nxt = value_r;
        end
      endcase
    end
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= cdsp_pkg::PS_IDLE;
      chan_r  <= '0;
      value_r <= '0;
    end else if (accept && (op == cdsp_pkg::OP_BYTE)) begin
      stage_r <= stage_nxt;
      chan_r  <= chan_nxt;
      value_r <= value_nxt;
    end
  end

endmodule

@@ hw/rtl/cdsp_fifo.sv @@
// short command queue between parser and frame timer
module cdsp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cdsp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cdsp_pkg::cmd_t head_cmd
);

  cdsp_pkg::cmd_t                entry_r [cdsp_pkg::QDEPTH];
  logic [cdsp_pkg::QPTR_W-1:0]   wr_r, wr_nxt;
  logic [cdsp_pkg::QPTR_W-1:0]   rd_r, rd_nxt;
  logic [cdsp_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count_r == cdsp_pkg::QCNT_W'(cdsp_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (do_push) begin
      wr_nxt = (wr_r == cdsp_pkg::QPTR_W'(cdsp_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == cdsp_pkg::QPTR_W'(cdsp_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/cdsp_back.sv @@
// frame timer, pulse widths and output register
module cdsp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  cdsp_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  input  cdsp_pkg::timing_cfg_t           timing,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [cdsp_pkg::CHANNELS-1:0]   levels
);

  logic [cdsp_pkg::WIDTH_BITS-1:0] width_r [cdsp_pkg::CHANNELS];
  logic [cdsp_pkg::WIDTH_BITS-1:0] width_nxt [cdsp_pkg::CHANNELS];
  logic [cdsp_pkg::CNT_W-1:0]      frame_r, frame_nxt;
  logic [cdsp_pkg::CNT_W-1:0]      pulse_r, pulse_nxt;
  logic [cdsp_pkg::CHANNELS-1:0]   levels_r, levels_nxt;
  logic                            valid_r, valid_nxt;

  logic                            wrap;
  logic [cdsp_pkg::CNT_W-1:0]      frame_e;
  logic [cdsp_pkg::CNT_W-1:0]      pulse_e;
  logic [cdsp_pkg::CHANNELS-1:0]   levels_e;

  assign q_pop     = q_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign levels    = levels_r;

  assign wrap     = (frame_r >= timing.frame_ticks);
  assign frame_e  = wrap ? '0 : frame_r;
  assign pulse_e  = wrap ? '0 : pulse_r;
  assign levels_e = wrap ? '0 : levels_r;

  always_comb begin
    frame_nxt  = frame_r;
    pulse_nxt  = pulse_r;
    levels_nxt = levels_r;
    for (int k = 0; k < cdsp_pkg::CHANNELS; k++) begin
      width_nxt[k] = width_r[k];
    end
    if (q_pop) begin
      case (q_cmd.kind)
        cdsp_pkg::CMD_TICK: begin
          frame_nxt = frame_e + 1'b1;
          if (frame_e <= timing.lead_ticks) begin
            pulse_nxt  = pulse_e;
            levels_nxt = '1;
          end else begin
            levels_nxt = levels_e;
            for (int k = 0; k < cdsp_pkg::CHANNELS; k++) begin
              levels_nxt[k] = (cdsp_pkg::CMP_W'(pulse_e) <=
                               cdsp_pkg::CMP_W'(width_r[k]));
            end
            pulse_nxt = (pulse_e == cdsp_pkg::CNT_MAX) ? pulse_e : pulse_e + 1'b1;
          end
        end
        cdsp_pkg::CMD_SET: begin
          for (int k = 0; k < cdsp_pkg::CHANNELS; k++) begin
            if (q_cmd.ch == cdsp_pkg::CH_W'(k)) begin
              width_nxt[k] = q_cmd.value;
            end
          end
        end
        default: begin
          levels_nxt = levels_r;
        end
      endcase
    end
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      pulse_r  <= '0;
      levels_r <= '0;
      valid_r  <= 1'b0;
      for (int k = 0; k < cdsp_pkg::CHANNELS; k++) begin
        width_r[k] <= cdsp_pkg::WIDTH_RESET;
      end
    end else begin
      frame_r  <= frame_nxt;
      pulse_r  <= pulse_nxt;
      levels_r <= levels_nxt;
      valid_r  <= valid_nxt;
      for (int k = 0; k < cdsp_pkg::CHANNELS; k++) begin
        width_r[k] <= width_nxt[k];
      end
    end
  end

endmodule

@@ hw/rtl/command_driven_servo_pulse_generator.sv @@
// top level of the servo pulse generator: config registers, parser, queue, timer
// an accepted item is written into the queue, and its result is loaded into the output register as it leaves
// throughput: one item per cycle while the queue is not full; while a result waits the two-entry queue takes
// two more items, and the output register loads the next result as the last leaves
// reset (rst_n low, synchronous): counters, levels, parser and queue clear,
// widths return to 90, config registers return to 1670 / 40 / group 1
module command_driven_servo_pulse_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte[7:0]
  input  logic       in_tuser,   // operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // pulse_a, pulse_b, pulse_c, zero pad[7:3]
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_wdata
);

  cdsp_pkg::timing_cfg_t                timing_r;
  logic                                 group_r;
  logic                                 accept;
  logic                                 push;
  cdsp_pkg::cmd_t                       push_cmd;
  logic                                 q_full;
  logic                                 q_valid;
  cdsp_pkg::cmd_t                       q_cmd;
  logic                                 q_pop;
  logic [cdsp_pkg::CHANNELS-1:0]        levels;
  logic [cdsp_pkg::CHANNELS+cdsp_pkg::OUT_BITS-1:0] levels_ext;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.frame_ticks <= cdsp_pkg::FRAME_TICKS_RESET;
      timing_r.lead_ticks  <= cdsp_pkg::LEAD_TICKS_RESET;
      group_r              <= cdsp_pkg::GROUP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cdsp_pkg::CFG_FRAME_TICKS:   timing_r.frame_ticks <= cfg_wdata;
        cdsp_pkg::CFG_LEAD_TICKS:    timing_r.lead_ticks  <= cfg_wdata;
        cdsp_pkg::CFG_CHANNEL_GROUP: group_r              <= cfg_wdata[0];
        default:                     group_r              <= group_r;
      endcase
    end
  end

  cdsp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .op      (in_tuser),
    .rx_byte (in_tdata),
    .group   (group_r),
    .push    (push),
    .cmd     (push_cmd)
  );

  cdsp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  cdsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .timing    (timing_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .levels    (levels)
  );

  assign levels_ext = (cdsp_pkg::CHANNELS + cdsp_pkg::OUT_BITS)'(levels);
  assign out_tdata  = {5'b0, levels_ext[cdsp_pkg::OUT_BITS-1:0]};

endmodule

@@ hw/rtl/cdsp_checker.sv @@
// port-level checks of the servo pulse generator, bound to the top level
`include "command_driven_servo_pulse_generator_defines.svh"

module cdsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `CDSP_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result offered after reset")
  `CDSP_ASSERT(a_stall_source, clk, rst_n, !in_tready |-> out_tvalid, "input stalled, no result")
  `CDSP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `CDSP_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "data moved")

endmodule

bind command_driven_servo_pulse_generator cdsp_checker u_checker (.*);

@@ tb/servo_pulse_checker.sv @@
// servo pulse generator checker: watches the item channels, predicts levels and compares
module servo_pulse_checker
  import cdsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  logic        in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // pulse_a, pulse_b, pulse_c, zero pad[7:3]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  output int          mismatch_count,
  output int          levels_pending
);

  logic [CNT_W-1:0]      frame_len;
  logic [CNT_W-1:0]      lead_len;
  logic                  group_sel;
  logic [WIDTH_BITS-1:0] width_q [CHANNELS];
  logic [CNT_W-1:0]      frame_cnt;
  logic [CNT_W-1:0]      pulse_cnt;
  parse_stage_t          stage;
  logic [CH_W-1:0]       chan_sel;
  int                    cmd_value;
  logic [OUT_BITS-1:0]   levels;

  logic [OUT_BITS-1:0]   levels_q [$];
  int                    errors = 0;
  int                    backlog = 0;
  string                 field_name [OUT_BITS] = '{"pulse_a", "pulse_b", "pulse_c"};

  assign mismatch_count = errors;
  assign levels_pending = backlog;

  task automatic servo_tick();
    if (frame_cnt >= frame_len) begin
      frame_cnt = '0;
      pulse_cnt = '0;
      levels    = '0;
    end
    frame_cnt = frame_cnt + 1'b1;
    if ((32'(frame_cnt) - 32'd1) <= 32'(lead_len)) begin
      for (int k = 0; k < CHANNELS; k++) levels[k] = 1'b1;
    end else begin
      for (int k = 0; k < CHANNELS; k++)
        levels[k] = CMP_W'(pulse_cnt) <= CMP_W'(width_q[k]);
      if (pulse_cnt != CNT_MAX) pulse_cnt = pulse_cnt + 1'b1;
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] base;
    base = group_sel ? CHR_4 : CHR_1;
    if (b == CHR_S) begin
      stage     = PS_CHAN;
      cmd_value = 0;
    end else begin
      case (stage)
        PS_CHAN: begin
          if (b >= base && int'(b - base) < CHANNELS) begin
            chan_sel  = CH_W'(b - base);
            cmd_value = 0;
            stage     = PS_D0;
          end else begin
            stage = PS_IDLE;
          end
        end
        PS_D0, PS_D1, PS_D2: begin
          if (b < CHR_0 || b > CHR_9) begin
            stage = PS_IDLE;
          end else begin
            cmd_value = cmd_value * 10 + int'(b - CHR_0);
            if (stage == PS_D2) begin
              if (int'(chan_sel) < CHANNELS)
                width_q[chan_sel] = (cmd_value > int'(WIDTH_MAX)) ?
                                    WIDTH_MAX : WIDTH_BITS'(cmd_value);
              stage = PS_IDLE;
            end else begin
              stage = (stage == PS_D0) ? PS_D1 : PS_D2;
            end
          end
        end
        default: stage = PS_IDLE;
      endcase
    end
  endtask

  always @(posedge clk) begin
    logic [OUT_BITS-1:0] want;
    if (!rst_n) begin
      frame_len = FRAME_TICKS_RESET;
      lead_len  = LEAD_TICKS_RESET;
      group_sel = GROUP_RESET;
      for (int k = 0; k < CHANNELS; k++) width_q[k] = WIDTH_RESET;
      frame_cnt = '0;
      pulse_cnt = '0;
      stage     = PS_IDLE;
      chan_sel  = '0;
      cmd_value = 0;
      levels    = '0;
      levels_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_TICKS:   frame_len = cfg_wdata[CNT_W-1:0];
          CFG_LEAD_TICKS:    lead_len  = cfg_wdata[CNT_W-1:0];
          CFG_CHANNEL_GROUP: group_sel = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_TICK) servo_tick();
        else parse_rx_byte(in_tdata);
        levels_q.push_back(levels);
      end
      if (out_tvalid && out_tready) begin
        if (levels_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item: out_tdata=%h", out_tdata);
        end else begin
          want = levels_q.pop_front();
          for (int k = 0; k < OUT_BITS; k++) begin
            if (out_tdata[k] !== want[k]) begin
              errors++;
              if (errors <= 10)
                $display("%s mismatch: expected %b, got %b", field_name[k], want[k],
                         out_tdata[k]);
            end
          end
          if (out_tdata[7:OUT_BITS] !== '0) begin
            errors++;
            if (errors <= 10) $display("pad mismatch: expected 0, got %h", out_tdata[7:OUT_BITS]);
          end
        end
      end
    end
    backlog <= levels_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// servo pulse generator testbench top: stimulus, receiver stalls, configuration phases, verdict
module testbench;
  import cdsp_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_THIRDS, RX_TRICKLE} rx_mode_t;

  localparam int PHASES = 7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_FRAME_TICKS;
  logic [11:0] cfg_wdata  = '0;

  int          mismatch_count;
  int          levels_pending;
  int          burst_left = 0;
  int          items_sent = 0;
  logic        cur_group  = GROUP_RESET;

  rx_mode_t    rx_mode    = RX_OPEN;
  int          rx_run     = 0;
  int          rx_cycle   = 0;

  int          frame_set [PHASES] = '{24, 1, 0, 4095, 50, 0, 12};
  int          lead_set  [PHASES] = '{3, 0, 4095, 0, 0, 0, 5};
  int          group_set [PHASES] = '{0, 1, 0, 1, 0, 0, 1};

  command_driven_servo_pulse_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  servo_pulse_checker u_pulse_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .levels_pending (levels_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stalls in runs of varying style
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_run == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_run  <= $urandom_range(5, 40);
    end else begin
      rx_run <= rx_run - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_THIRDS: out_tready <= (rx_cycle % 3) != 0;
      default:   out_tready <= (rx_cycle % 6) == 0;
    endcase
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_command(input logic [7:0] chan_digit, input int value);
    send_item(OP_BYTE, CHR_S);
    send_item(OP_BYTE, chan_digit);
    send_item(OP_BYTE, CHR_0 + 8'(value / 100));
    send_item(OP_BYTE, CHR_0 + 8'((value / 10) % 10));
    send_item(OP_BYTE, CHR_0 + 8'(value % 10));
  endtask

  function automatic logic [7:0] pick_channel_digit();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(CHR_0, CHR_9));
    return (cur_group ? CHR_4 : CHR_1) + 8'($urandom_range(0, CHANNELS - 1));
  endfunction

  function automatic int pick_width();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 40);
  endfunction

  // wait until every predicted item has come back and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (levels_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input int frame, input int lead, input int group);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_TICKS;
    cfg_wdata <= 12'(frame);
    @(posedge clk);
    cfg_index <= CFG_LEAD_TICKS;
    cfg_wdata <= 12'(lead);
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_GROUP;
    cfg_wdata <= 12'(group);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_group = 1'(group);
  endtask

  task automatic random_phase(input int count);
    int start;
    int pick;
    int n;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 20);
        repeat (n) send_tick();
      end else if (pick < 80) begin
        send_command(pick_channel_digit(), pick_width());
      end else if (pick < 90) begin
        // truncated command followed by any byte
        send_item(OP_BYTE, CHR_S);
        n = $urandom_range(0, 3);
        if (n > 0) send_item(OP_BYTE, pick_channel_digit());
        for (int i = 1; i < n; i++) send_item(OP_BYTE, 8'($urandom_range(CHR_0, CHR_9)));
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under the reset setting (group of digits 4-6)
    send_item(OP_TICK, 8'hFF);
    send_command(CHR_4, 5);
    send_command(CHR_4 + 8'd2, 999);
    send_item(OP_BYTE, CHR_S);
    send_item(OP_BYTE, CHR_1);
    send_item(OP_BYTE, CHR_S);
    send_item(OP_BYTE, CHR_4 + 8'd1);
    send_item(OP_BYTE, CHR_1);
    send_command(CHR_4 + 8'd1, 7);
    send_item(OP_BYTE, CHR_S);
    send_item(OP_BYTE, CHR_4 + 8'd1);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);

    random_phase(50);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 5) begin
        frame_set[p] = $urandom_range(2, 80);
        lead_set[p]  = $urandom_range(0, 10);
        group_set[p] = $urandom_range(0, 1);
      end
      apply_setting(frame_set[p], lead_set[p], group_set[p]);
      random_phase(50);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
